### hw/rtl/tmrs_pkg.sv
package tmrs_pkg;

  localparam int unsigned DEF_RING_SLOTS   = 128;
  localparam int unsigned DEF_MAX_RECORDS  = 64;
  localparam int unsigned MAX_SLOTS_IN_USE = 100;

  localparam logic [1:0] KIND_MSG     = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_RECORD  = 2'd2;

  localparam logic [3:0] TYPE_SCALER = 4'd7;
  localparam logic [2:0] POS_SECOND  = 3'd4;
  localparam logic [2:0] POS_GROUP1  = 3'd5;
  localparam logic [2:0] POS_GROUP2  = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] seconds_back;
    logic [5:0]  record_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  response_kind;
    logic [30:0] second_value;
    logic [6:0]  record_count;
    logic [19:0] scaler_value;
    logic [3:0]  trigger_type;
    logic [19:0] trigger_usec;
    logic        record_valid;
    logic        gap_seen;
    logic [30:0] gap_seconds;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [6:0]  cnt;
    logic [19:0] scl;
  } slot_row_t;

  typedef struct packed {
    logic [3:0]  rtype;
    logic [19:0] usec;
  } rec_row_t;

  typedef struct packed {
    logic accept;
    logic cfg_we;
    logic mod_start;
    logic load_rd;
    logic adv;
    logic byte_do;
    logic done_do;
    logic sel_rd;
    logic resp_do;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] in_kind;
    logic       pos_zero;
    logic       last;
    logic       mod_busy;
    logic       out_free;
  } ctrl_sts_t;

endpackage

### hw/rtl/tmrs_ram.sv
module tmrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tmrs_mod.sv
module tmrs_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        busy_o,
  output logic [6:0]  rem_o
);

  logic        busy_q, busy_d;
  logic [4:0]  step_q, step_d;
  logic [6:0]  rem_q, rem_d;
  logic [15:0] shift_q, shift_d;
  logic [7:0]  trial;

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    rem_d   = rem_q;
    shift_d = shift_q;
    trial   = {rem_q, shift_q[15]};
    if (start_i) begin
      busy_d  = 1'b1;
      step_d  = 5'd16;
      rem_d   = '0;
      shift_d = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = 7'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[6:0];
      end
      shift_d = {shift_q[14:0], 1'b0};
      step_d  = step_q - 5'd1;
      if (step_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= '0;
      rem_q   <= '0;
      shift_q <= '0;
    end else begin
      busy_q  <= busy_d;
      step_q  <= step_d;
      rem_q   <= rem_d;
      shift_q <= shift_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/tmrs_dpath.sv
module tmrs_dpath #(
  parameter int unsigned RING_SLOTS  = tmrs_pkg::DEF_RING_SLOTS,
  parameter int unsigned MAX_RECORDS = tmrs_pkg::DEF_MAX_RECORDS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmrs_pkg::in_item_t  in_data_i,
  input  logic [6:0]          cfg_data_i,
  input  tmrs_pkg::ctrl_cmd_t cmd_i,
  output tmrs_pkg::ctrl_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tmrs_pkg::out_item_t out_data_o
);

  localparam int unsigned SlotW    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int unsigned RecDepth = RING_SLOTS * MAX_RECORDS;
  localparam int unsigned RecAw    = (RecDepth > 1) ? $clog2(RecDepth) : 1;
  localparam int unsigned LimitSlots =
      (RING_SLOTS < tmrs_pkg::MAX_SLOTS_IN_USE) ? RING_SLOTS : tmrs_pkg::MAX_SLOTS_IN_USE;
  localparam logic [6:0] MaxCnt = 7'(MAX_RECORDS);
  localparam int unsigned SlotRowW = $bits(tmrs_pkg::slot_row_t);
  localparam int unsigned RecRowW  = $bits(tmrs_pkg::rec_row_t);

  logic [6:0]            slots_q, slots_d;
  logic [SlotW-1:0]      head_q, head_d;
  logic [2:0]            pos_q, pos_d;
  logic [31:0]           hdr_q, hdr_d;
  logic [15:0]           grp_q, grp_d;
  logic [31:0]           prev_q, prev_d;
  logic                  drop_q, drop_d;
  tmrs_pkg::slot_row_t   row_q, row_d;
  logic [RING_SLOTS-1:0] vld_q, vld_d;
  logic                  rd_vld_q;
  logic                  out_valid_q, out_valid_d;
  tmrs_pkg::out_item_t   out_q, out_d;
  tmrs_pkg::in_item_t    item_q;

  logic [SlotW-1:0]      h_next;
  logic [SlotW-1:0]      sel_slot;
  logic [7:0]            head_ext;
  logic [7:0]            sel_diff;
  logic [6:0]            mod_rem;
  logic                  mod_busy;
  logic                  out_free;
  logic                  cfg_ok;
  logic [3:0]            grp_type;
  logic [19:0]           grp_val;
  logic [32:0]           sec_diff;
  logic                  gap;
  logic                  rec_ok;

  logic                  slot_we;
  logic [SlotW-1:0]      slot_waddr;
  tmrs_pkg::slot_row_t   slot_wdata;
  logic                  slot_re;
  logic [SlotW-1:0]      slot_raddr;
  logic [SlotRowW-1:0]   slot_rdata;
  tmrs_pkg::slot_row_t   slot_rd_row;

  logic                  rec_we;
  logic [RecAw-1:0]      rec_waddr;
  tmrs_pkg::rec_row_t    rec_wdata;
  logic [RecAw-1:0]      rec_raddr;
  logic [RecRowW-1:0]    rec_rdata;
  tmrs_pkg::rec_row_t    rec_rd_row;

  tmrs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (in_data_i.seconds_back),
    .divisor_i  (slots_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  tmrs_ram #(
    .WIDTH (SlotRowW),
    .DEPTH (RING_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  tmrs_ram #(
    .WIDTH (RecRowW),
    .DEPTH (RecDepth)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .re_i    (cmd_i.sel_rd),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign slot_rd_row = rd_vld_q ? tmrs_pkg::slot_row_t'(slot_rdata) : '0;
  assign rec_rd_row  = tmrs_pkg::rec_row_t'(rec_rdata);
  assign cfg_ok      = (cfg_data_i != 7'd0) && (cfg_data_i <= 7'(LimitSlots));

  // ring position for queries and the next head
  assign h_next   = (head_q == SlotW'(slots_q - 7'd1)) ? '0 : head_q + SlotW'(1);
  assign head_ext = 8'(head_q);
  assign sel_diff = (head_ext >= {1'b0, mod_rem}) ? head_ext - {1'b0, mod_rem}
                                                  : head_ext + {1'b0, slots_q} - {1'b0, mod_rem};
  assign sel_slot = SlotW'(sel_diff);

  assign slot_re    = cmd_i.load_rd | cmd_i.sel_rd;
  assign slot_raddr = cmd_i.sel_rd ? sel_slot : h_next;
  assign slot_waddr = cmd_i.adv ? h_next : head_q;
  assign slot_wdata = row_d;

  assign rec_waddr = RecAw'(RecAw'(head_q) * RecAw'(MAX_RECORDS)) + RecAw'(row_q.cnt);
  assign rec_raddr = RecAw'(RecAw'(sel_slot) * RecAw'(MAX_RECORDS))
                   + RecAw'(item_q.record_index);

  assign grp_type = grp_q[15:12];
  assign grp_val  = {grp_q[11:0], item_q.data_byte};

  assign sec_diff = {row_q.sec[31], row_q.sec} - {prev_q[31], prev_q};
  assign gap      = (row_q.cnt != 7'd0) && !prev_q[31] && (prev_q != 32'd0)
                 && !sec_diff[32] && (sec_diff[31:1] != 31'd0);

  assign rec_ok = (item_q.kind == tmrs_pkg::KIND_RECORD)
               && ({1'b0, item_q.record_index} < slot_rd_row.cnt)
               && ({1'b0, item_q.record_index} < MaxCnt);

  always_comb begin
    slots_d     = slots_q;
    head_d      = head_q;
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    grp_d       = grp_q;
    prev_d      = prev_q;
    drop_d      = drop_q;
    row_d       = row_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    slot_we     = 1'b0;
    rec_we      = 1'b0;
    rec_wdata   = '{rtype: grp_type, usec: grp_val};

    if (cmd_i.cfg_we && cfg_ok) begin
      slots_d = cfg_data_i;
      head_d  = SlotW'(cfg_data_i - 7'd1);
      pos_d   = '0;
      hdr_d   = '0;
      grp_d   = '0;
      prev_d  = '0;
      drop_d  = 1'b0;
      row_d   = '0;
      vld_d   = '0;
    end

    // first beat of a message: move the head and load its slot
    if (cmd_i.adv) begin
      prev_d    = row_q.sec;
      head_d    = h_next;
      row_d.sec = slot_rd_row.sec;
      row_d.scl = slot_rd_row.scl;
      row_d.cnt = '0;
      drop_d    = 1'b0;
      hdr_d     = '0;
      slot_we   = 1'b1;
    end

    if (cmd_i.byte_do) begin
      if (pos_q < tmrs_pkg::POS_SECOND) begin
        hdr_d = {hdr_q[23:0], item_q.data_byte};
        pos_d = pos_q + 3'd1;
      end else if (pos_q == tmrs_pkg::POS_SECOND) begin
        row_d.sec = hdr_q;
        grp_d     = {8'd0, item_q.data_byte};
        pos_d     = tmrs_pkg::POS_GROUP1;
        slot_we   = 1'b1;
      end else if (pos_q == tmrs_pkg::POS_GROUP1) begin
        grp_d = {grp_q[7:0], item_q.data_byte};
        pos_d = tmrs_pkg::POS_GROUP2;
      end else begin
        if (grp_type == tmrs_pkg::TYPE_SCALER) begin
          row_d.scl = grp_val;
          slot_we   = 1'b1;
        end else if (row_q.cnt < MaxCnt) begin
          rec_we    = 1'b1;
          row_d.cnt = row_q.cnt + 7'd1;
          slot_we   = 1'b1;
        end else begin
          drop_d = 1'b1;
        end
        pos_d = tmrs_pkg::POS_SECOND;
      end
    end

    if (slot_we) begin
      vld_d[slot_waddr] = 1'b1;
    end

    if (cmd_i.done_do) begin
      out_valid_d         = 1'b1;
      out_d               = '0;
      out_d.response_kind = tmrs_pkg::KIND_MSG;
      out_d.second_value  = row_q.sec[30:0];
      out_d.record_count  = row_q.cnt;
      out_d.scaler_value  = row_q.scl;
      out_d.gap_seen      = gap;
      out_d.gap_seconds   = gap ? sec_diff[30:0] : '0;
      out_d.overflow      = drop_q;
      pos_d               = '0;
      drop_d              = 1'b0;
    end

    if (cmd_i.resp_do) begin
      out_valid_d         = 1'b1;
      out_d               = '0;
      out_d.response_kind = item_q.kind;
      out_d.second_value  = slot_rd_row.sec[30:0];
      out_d.record_count  = slot_rd_row.cnt;
      out_d.scaler_value  = slot_rd_row.scl;
      if (rec_ok) begin
        out_d.trigger_type = rec_rd_row.rtype;
        out_d.trigger_usec = rec_rd_row.usec;
        out_d.record_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= 7'(LimitSlots);
      head_q      <= SlotW'(LimitSlots - 1);
      pos_q       <= '0;
      hdr_q       <= '0;
      grp_q       <= '0;
      prev_q      <= '0;
      drop_q      <= 1'b0;
      row_q       <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slots_q     <= slots_d;
      head_q      <= head_d;
      pos_q       <= pos_d;
      hdr_q       <= hdr_d;
      grp_q       <= grp_d;
      prev_q      <= prev_d;
      drop_q      <= drop_d;
      row_q       <= row_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      if (slot_re) begin
        rd_vld_q <= vld_q[slot_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign sts_o.in_kind  = in_data_i.kind;
  assign sts_o.pos_zero = (pos_q == 3'd0);
  assign sts_o.last     = item_q.last_byte;
  assign sts_o.mod_busy = mod_busy;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/tmrs_ctrl.sv
module tmrs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                cfg_valid_i,
  input  tmrs_pkg::ctrl_sts_t sts_i,
  output tmrs_pkg::ctrl_cmd_t cmd_o,
  output logic                in_stall_o,
  output logic                cfg_ready_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_ADV  = 8'b0000_0100,
    ST_BYTE = 8'b0000_1000,
    ST_DONE = 8'b0001_0000,
    ST_MOD  = 8'b0010_0000,
    ST_SEL  = 8'b0100_0000,
    ST_RESP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   idle;

  assign idle = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.cfg_we = cfg_valid_i && idle;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (sts_i.in_kind)
            tmrs_pkg::KIND_MSG: begin
              state_d = sts_i.pos_zero ? ST_LOAD : ST_BYTE;
            end
            tmrs_pkg::KIND_SUMMARY, tmrs_pkg::KIND_RECORD: begin
              cmd_o.mod_start = 1'b1;
              state_d         = ST_MOD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.load_rd = 1'b1;
        state_d       = ST_ADV;
      end
      ST_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = ST_BYTE;
      end
      ST_BYTE: begin
        cmd_o.byte_do = 1'b1;
        state_d       = sts_i.last ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_do = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (!sts_i.mod_busy) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.sel_rd = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_do = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;

endmodule

### hw/rtl/trigger_message_ring_store_unit.sv
// channel   direction  handshake            payload
// in        input      in_valid_i/in_stall_o    tmrs_pkg::in_item_t
// out       output     out_valid_o/out_stall_i  tmrs_pkg::out_item_t
// cfg       input      cfg_valid_i/cfg_ready_o  slots_in_use, 7 bits
//
// message beat: IDLE, BYTE; first also LOAD (slot ram read) and ADV; last also DONE
// query: waits on the bit-serial remainder of seconds_back by slots_in_use
// reset clears slot state at once through per-slot valid bits, no clearing pass
// a finished message or query sits in the output register; the next item is taken meanwhile
// and its own result waits until that register is free
module trigger_message_ring_store_unit #(
  parameter int unsigned RING_SLOTS  = tmrs_pkg::DEF_RING_SLOTS,
  parameter int unsigned MAX_RECORDS = tmrs_pkg::DEF_MAX_RECORDS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tmrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tmrs_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [6:0]          cfg_data_i
);

  tmrs_pkg::ctrl_cmd_t cmd;
  tmrs_pkg::ctrl_sts_t sts;

  tmrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o)
  );

  tmrs_dpath #(
    .RING_SLOTS  (RING_SLOTS),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
